/* rtl/fcl_pkg.sv */
// shared types and constants of the fat12 cluster chain lookup
package fcl_pkg;

  // fixed field widths
  localparam int ADDR_BITS     = 13;
  localparam int CLUSTER_BITS  = 12;
  localparam int QUOT_BITS     = 21;
  localparam int SECTOR_BITS   = 13;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 16;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_BITS-1:0] REG_RESERVED_COUNT  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_TABLE_SECTORS   = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_TABLE_COPIES    = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_ROOT_ENTRIES    = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_SECTOR_BYTES    = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_CLUSTER_SECTORS = 3'd5;

  // register reset values
  localparam logic [15:0] RST_RESERVED_COUNT  = 16'd1;
  localparam logic [15:0] RST_TABLE_SECTORS   = 16'd9;
  localparam logic [7:0]  RST_TABLE_COPIES    = 8'd2;
  localparam logic [15:0] RST_ROOT_ENTRIES    = 16'd224;
  localparam logic [12:0] RST_SECTOR_BYTES    = 13'd512;
  localparam logic [7:0]  RST_CLUSTER_SECTORS = 8'd1;

  // cluster codes and nibble mask
  localparam logic [CLUSTER_BITS-1:0] CHAIN_END_MIN      = 12'hFF8;
  localparam logic [CLUSTER_BITS-1:0] FIRST_DATA_CLUSTER = 12'd2;
  localparam logic [3:0]              NIBBLE_MASK        = 4'hF;

  // input function codes
  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  typedef struct packed {
    logic                    func;
    logic [ADDR_BITS-1:0]    byte_offset;
    logic [7:0]              byte_value;
    logic [CLUSTER_BITS-1:0] cluster;
  } in_word_t;

  typedef struct packed {
    logic [CLUSTER_BITS-1:0] next_cluster;
    logic [31:0]             data_lba;
    logic [23:0]             root_start_lba;
    logic [QUOT_BITS-1:0]    root_sector_count;
    logic                    chain_end;
    logic                    reserved_cluster;
  } out_word_t;

  // volume geometry derived from the registers
  typedef struct packed {
    logic [23:0]          root_start;
    logic [QUOT_BITS-1:0] root_count;
    logic [24:0]          lba_base;
    logic [7:0]           cluster_sectors;
  } geom_t;

  typedef enum logic [1:0] {
    G_DIVIDE,
    G_SUM,
    G_BASE,
    G_READY
  } geom_state_t;

endpackage

/* rtl/fcl_table.sv */
// allocation table byte memory, one write port and two registered read ports
module fcl_table #(
  parameter int TABLE_DEPTH = 8192,
  parameter int AW          = 13
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr0,
  input  logic [AW-1:0] raddr1,
  output logic [7:0]    rdata0,
  output logic [7:0]    rdata1
);

  logic [7:0] mem [TABLE_DEPTH];
  logic [7:0] rdata0_r;
  logic [7:0] rdata1_r;

  // byte write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // two registered reads
  always_ff @(posedge clk) begin
    rdata0_r <= mem[raddr0];
    rdata1_r <= mem[raddr1];
  end

  assign rdata0 = rdata0_r;
  assign rdata1 = rdata1_r;

endmodule

/* rtl/fcl_geom.sv */
// configuration registers and sequential computation of the volume geometry
module fcl_geom (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [fcl_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [fcl_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  output fcl_pkg::geom_t                      geom,
  output logic                                busy
);
  import fcl_pkg::*;

  logic [15:0] rc_r;
  logic [15:0] ts_r;
  logic [7:0]  tc_r;
  logic [15:0] re_r;
  logic [12:0] sb_r;
  logic [7:0]  cs_r;

  geom_state_t          state_r, state_nxt;
  logic [4:0]           step_r, step_nxt;
  logic [12:0]          rem_r, rem_nxt;
  logic [QUOT_BITS-1:0] q_r, q_nxt;
  logic [QUOT_BITS-1:0] root_count_r, root_count_nxt;
  logic [23:0]          root_start_r, root_start_nxt;
  logic [24:0]          lba_base_r, lba_base_nxt;

  logic [QUOT_BITS-1:0] num;
  logic [12:0]          div_val;
  logic [4:0]           bit_idx;
  logic [13:0]          trial;
  logic [13:0]          div_ext;
  logic                 ge;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rc_r <= RST_RESERVED_COUNT;
      ts_r <= RST_TABLE_SECTORS;
      tc_r <= RST_TABLE_COPIES;
      re_r <= RST_ROOT_ENTRIES;
      sb_r <= RST_SECTOR_BYTES;
      cs_r <= RST_CLUSTER_SECTORS;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RESERVED_COUNT:  rc_r <= cfg_data;
        REG_TABLE_SECTORS:   ts_r <= cfg_data;
        REG_TABLE_COPIES:    tc_r <= cfg_data[7:0];
        REG_ROOT_ENTRIES:    re_r <= cfg_data;
        REG_SECTOR_BYTES:    sb_r <= cfg_data[12:0];
        REG_CLUSTER_SECTORS: cs_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // one restoring divide step per cycle: entries * 32 / sector size
  assign num     = {re_r, 5'b0};
  assign div_val = (sb_r == '0) ? 13'd1 : sb_r;
  assign div_ext = {1'b0, div_val};
  assign bit_idx = 5'(QUOT_BITS - 1) - step_r;
  assign trial   = {rem_r, num[bit_idx]};
  assign ge      = trial >= div_ext;

  // sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= G_DIVIDE;
      step_r  <= '0;
      rem_r   <= '0;
      q_r     <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      rem_r   <= rem_nxt;
      q_r     <= q_nxt;
    end
  end

  always_ff @(posedge clk) begin
    root_count_r <= root_count_nxt;
    root_start_r <= root_start_nxt;
    lba_base_r   <= lba_base_nxt;
  end

  // next state: divide, round up and start sector, then base sum
  always_comb begin
    state_nxt      = state_r;
    step_nxt       = step_r;
    rem_nxt        = rem_r;
    q_nxt          = q_r;
    root_count_nxt = root_count_r;
    root_start_nxt = root_start_r;
    lba_base_nxt   = lba_base_r;
    case (state_r)
      G_DIVIDE: begin
        rem_nxt  = ge ? 13'(trial - div_ext) : trial[12:0];
        q_nxt    = {q_r[QUOT_BITS-2:0], ge};
        step_nxt = step_r + 5'd1;
        if (step_r == 5'(QUOT_BITS - 1)) begin
          state_nxt = G_SUM;
        end
      end
      G_SUM: begin
        root_count_nxt = q_r + QUOT_BITS'(rem_r != '0);
        root_start_nxt = 24'(rc_r) + 24'(ts_r) * 24'(tc_r);
        state_nxt      = G_BASE;
      end
      G_BASE: begin
        lba_base_nxt = 25'(root_start_r) + 25'(root_count_r);
        state_nxt    = G_READY;
      end
      G_READY: ;
      default: state_nxt = G_DIVIDE;
    endcase
    // any register write starts the computation over
    if (cfg_we) begin
      state_nxt = G_DIVIDE;
      step_nxt  = '0;
      rem_nxt   = '0;
      q_nxt     = '0;
    end
  end

  assign busy                 = state_r != G_READY;
  assign geom.root_start      = root_start_r;
  assign geom.root_count      = root_count_r;
  assign geom.lba_base        = lba_base_r;
  assign geom.cluster_sectors = cs_r;

  // a write always forces a fresh computation
  a_cfg_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> busy)
    else $error("register write did not restart geometry computation");

  // once ready, geometry holds until the next write
  a_ready_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!busy && !cfg_we) |=> (!busy && $stable(geom)))
    else $error("geometry changed without a register write");

endmodule

/* rtl/fcl_pipe.sv */
// lookup pipeline: table access, unpack and multiply, sector address
module fcl_pipe #(
  parameter int TABLE_DEPTH = 8192
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               acc,
  input  fcl_pkg::in_word_t  in_word,
  input  fcl_pkg::geom_t     geom,
  output logic               out_valid,
  output fcl_pkg::out_word_t out_word
);
  import fcl_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam logic [ADDR_BITS:0] DEPTH_W = (ADDR_BITS + 1)'(TABLE_DEPTH);

  logic                 wr_en;
  logic [ADDR_BITS-1:0] addr0;
  logic [ADDR_BITS-1:0] addr1;
  logic                 ok0;
  logic                 ok1;
  logic                 off_ok;
  logic [7:0]           rd0;
  logic [7:0]           rd1;

  logic                    v1_r;
  logic [CLUSTER_BITS-1:0] cl1_r;
  logic                    ok0_r;
  logic                    ok1_r;

  logic [7:0]              b0;
  logic [7:0]              b1;
  logic [CLUSTER_BITS-1:0] next;
  logic [CLUSTER_BITS-1:0] cl_off;

  logic                    v2_r;
  logic [CLUSTER_BITS-1:0] next2_r;
  logic                    end2_r;
  logic                    rsv2_r;
  logic [19:0]             prod2_r;

  logic      out_valid_r;
  out_word_t out_r;

  // stage 0: byte address of the entry, range checks, table access
  assign addr0  = ADDR_BITS'(in_word.cluster) + ADDR_BITS'(in_word.cluster >> 1);
  assign addr1  = addr0 + ADDR_BITS'(1);
  assign ok0    = {1'b0, addr0} < DEPTH_W;
  assign ok1    = {1'b0, addr1} < DEPTH_W;
  assign off_ok = {1'b0, in_word.byte_offset} < DEPTH_W;
  assign wr_en  = acc && (in_word.func == FUNC_WRITE) && off_ok;

  fcl_table #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .AW         (AW)
  ) u_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (in_word.byte_offset[AW-1:0]),
    .wdata (in_word.byte_value),
    .raddr0(addr0[AW-1:0]),
    .raddr1(addr1[AW-1:0]),
    .rdata0(rd0),
    .rdata1(rd1)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= acc && (in_word.func == FUNC_LOOKUP);
    end
  end

  always_ff @(posedge clk) begin
    cl1_r <= in_word.cluster;
    ok0_r <= ok0;
    ok1_r <= ok1;
  end

  // stage 1: unpack the 12-bit entry, flags, cluster offset product
  assign b0     = ok0_r ? rd0 : 8'd0;
  assign b1     = ok1_r ? rd1 : 8'd0;
  assign next   = cl1_r[0] ? {b1, b0[7:4]} : {b1[3:0] & NIBBLE_MASK, b0};
  assign cl_off = cl1_r - FIRST_DATA_CLUSTER;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    next2_r <= next;
    end2_r  <= cl1_r >= CHAIN_END_MIN;
    rsv2_r  <= cl1_r < FIRST_DATA_CLUSTER;
    prod2_r <= 20'(cl_off) * 20'(geom.cluster_sectors);
  end

  // stage 2: sector address and result word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    out_r.next_cluster      <= next2_r;
    out_r.data_lba          <= (end2_r || rsv2_r) ? 32'd0
                               : 32'(geom.lba_base) + 32'(prod2_r);
    out_r.root_start_lba    <= geom.root_start;
    out_r.root_sector_count <= geom.root_count;
    out_r.chain_end         <= end2_r;
    out_r.reserved_cluster  <= rsv2_r;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  // every result comes from an accepted lookup, carried through v1_r and v2_r
  a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(acc && (in_word.func == FUNC_LOOKUP), 3))
    else $error("result without a matching lookup");

  // flagged clusters give a zero sector address
  a_flag_zero_lba: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && (end2_r || rsv2_r)) |=> (out_valid_r && out_r.data_lba == 32'd0))
    else $error("flagged cluster produced a nonzero sector address");

endmodule

/* rtl/fat12_cluster_chain_lookup.sv */
// top level of the fat12 cluster chain lookup
//
// Usage: one word enters on in_word at a rising edge where start is high
// and busy is low. func = write stores byte_value at byte_offset in the
// allocation table and gives no result; offsets at or past TABLE_DEPTH are
// dropped. func = lookup reads the 12-bit entry of cluster and returns one
// out_word with the next cluster, the data sector address, root directory
// start and size, and the chain end and reserved flags.
// Throughput: one word per cycle while busy is low, writes and lookups
// mixed freely; a lookup right after a write sees the new byte.
// Output: each accepted lookup has out_valid high for exactly one cycle
// (three-stage pipeline: table read, unpack and multiply, address sum).
// The receiver cannot stall the block.
// Configuration: cfg_we, cfg_index, cfg_data write one register per cycle.
// The user must write only while no lookup is in flight; the block does not
// enforce this. Each write restarts the geometry sequencer, a bit-serial
// divider for the root directory size; busy stays high until it is done.
// Reset: synchronous on rst_n low; registers take their defaults and the
// same computation runs with busy high. Table contents are undefined
// until written.
module fat12_cluster_chain_lookup #(
  parameter int TABLE_DEPTH = 8192
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  fcl_pkg::in_word_t                   in_word,
  output logic                                out_valid,
  output fcl_pkg::out_word_t                  out_word,
  input  logic                                cfg_we,
  input  logic [fcl_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [fcl_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
  import fcl_pkg::*;

  geom_t geom;
  logic  geom_busy;
  logic  acc;

  // geometry registers and sequencer
  fcl_geom u_geom (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .geom     (geom),
    .busy     (geom_busy)
  );

  // word accepted while geometry is settled
  assign acc  = start && !geom_busy;
  assign busy = geom_busy;

  fcl_pipe #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_pipe (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc      (acc),
    .in_word  (in_word),
    .geom     (geom),
    .out_valid(out_valid),
    .out_word (out_word)
  );

endmodule

/* dv/tb_top.sv */
// self-checking testbench of the fat12 cluster chain lookup
module tb_top;
  import fcl_pkg::*;

  localparam int          DEPTH            = 8192;
  localparam int          PHASES           = 8;
  localparam int unsigned RANDOM_PER_PHASE = 185;
  localparam int unsigned WATCHDOG_LIMIT   = 2000;
  localparam int unsigned LATENCY_GUARD    = 8;

  // indexes past the last register, the block must ignore them
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_HI = 3'd7;

  // root geometry under reset register values
  localparam logic [23:0]          DEF_ROOT_START = 24'd19;
  localparam logic [QUOT_BITS-1:0] DEF_ROOT_COUNT = 21'd14;

  typedef struct {
    in_word_t  word;
    bit        has_exp;
    out_word_t exp;
  } stim_row_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  in_word_t                 in_word = '0;
  logic                     out_valid;
  out_word_t                out_word;
  logic                     cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  // shadow copy of the allocation table and the geometry registers
  logic [7:0]  fat_image [DEPTH];
  bit          fat_written [DEPTH];
  logic [15:0] geo_reserved;
  logic [15:0] geo_tsec;
  logic [7:0]  geo_copies;
  logic [15:0] geo_entries;
  logic [12:0] geo_sbytes;
  logic [7:0]  geo_csec;

  out_word_t   expected_words[$];
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  logic [11:0] chain_next = '0;

  always #4 clk = ~clk;

  fat12_cluster_chain_lookup #(.TABLE_DEPTH(DEPTH)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  function automatic logic [7:0] fat_byte(int unsigned addr);
    return (addr < DEPTH) ? fat_image[addr] : 8'h00;
  endfunction

  // next cluster, data sector and root geometry of one lookup
  function automatic out_word_t predict_lookup(logic [11:0] cl);
    int unsigned addr;
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [31:0] root_start;
    logic [31:0] root_bytes;
    logic [31:0] divisor;
    logic [31:0] root_count;
    out_word_t   r;
    addr = 32'(cl);
    addr = addr + (addr >> 1);
    b0 = fat_byte(addr);
    b1 = fat_byte(addr + 1);
    // odd clusters sit in the upper nibble of the first byte
    if (cl[0]) r.next_cluster = {b1, b0[7:4]};
    else r.next_cluster = {b1[3:0], b0};
    root_start = 32'(geo_reserved) + 32'(geo_tsec) * 32'(geo_copies);
    root_bytes = 32'(geo_entries) * 32'd32;
    divisor = (geo_sbytes == '0) ? 32'd1 : 32'(geo_sbytes);
    root_count = (root_bytes + divisor - 32'd1) / divisor;
    r.chain_end = (cl >= CHAIN_END_MIN);
    r.reserved_cluster = (cl < FIRST_DATA_CLUSTER);
    if (r.chain_end || r.reserved_cluster) r.data_lba = '0;
    else r.data_lba = root_start + root_count
                      + (32'(cl) - 32'(FIRST_DATA_CLUSTER)) * 32'(geo_csec);
    r.root_start_lba = root_start[23:0];
    r.root_sector_count = root_count[QUOT_BITS-1:0];
    return r;
  endfunction

  function automatic stim_row_t write_row(int unsigned off, int unsigned val);
    stim_row_t row;
    row.word = '0;
    row.word.func = FUNC_WRITE;
    row.word.byte_offset = off[ADDR_BITS-1:0];
    row.word.byte_value = val[7:0];
    row.has_exp = 1'b0;
    row.exp = '0;
    return row;
  endfunction

  function automatic stim_row_t lookup_row(int unsigned cl);
    stim_row_t row;
    row.word = '0;
    row.word.func = FUNC_LOOKUP;
    row.word.cluster = cl[CLUSTER_BITS-1:0];
    row.has_exp = 1'b0;
    row.exp = '0;
    return row;
  endfunction

  // lookup whose result is typed in, under reset geometry
  function automatic stim_row_t known_row(int unsigned cl, int unsigned nxt, int unsigned lba,
                                          bit ce, bit rc);
    stim_row_t row;
    row = lookup_row(cl);
    row.has_exp = 1'b1;
    row.exp.next_cluster = nxt[CLUSTER_BITS-1:0];
    row.exp.data_lba = lba;
    row.exp.root_start_lba = DEF_ROOT_START;
    row.exp.root_sector_count = DEF_ROOT_COUNT;
    row.exp.chain_end = ce;
    row.exp.reserved_cluster = rc;
    return row;
  endfunction

  function automatic int unsigned next_gap(bit burst);
    return burst ? 0 : $urandom_range(0, 8);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    $display("mismatch %s: got 0x%0h expected 0x%0h", what, got, want);
  endtask

  // present one word until it is taken, then update the shadow state
  task automatic send_item(stim_row_t row, int unsigned gap);
    out_word_t want;
    start <= 1'b1;
    in_word <= row.word;
    do @(posedge clk); while (busy !== 1'b0);
    if (row.word.func == FUNC_WRITE) begin
      if (row.word.byte_offset < DEPTH) begin
        fat_image[row.word.byte_offset] = row.word.byte_value;
        fat_written[row.word.byte_offset] = 1'b1;
      end
    end else begin
      want = row.has_exp ? row.exp : predict_lookup(row.word.cluster);
      expected_words.push_back(want);
      chain_next = want.next_cluster;
    end
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // hold off until every lookup has returned and the pipe is empty
  task automatic drain();
    start <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(logic [CFG_IDX_BITS-1:0] idx, logic [15:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      REG_RESERVED_COUNT:  geo_reserved = data;
      REG_TABLE_SECTORS:   geo_tsec = data;
      REG_TABLE_COPIES:    geo_copies = data[7:0];
      REG_ROOT_ENTRIES:    geo_entries = data;
      REG_SECTOR_BYTES:    geo_sbytes = data[12:0];
      REG_CLUSTER_SECTORS: geo_csec = data[7:0];
      default: ;
    endcase
  endtask

  task automatic program_geometry(logic [15:0] rsv, logic [15:0] tsec, logic [15:0] copies,
                                  logic [15:0] entries, logic [15:0] sbytes,
                                  logic [15:0] csec);
    drain();
    write_register($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO, 16'($urandom));
    write_register(REG_RESERVED_COUNT, rsv);
    write_register(REG_TABLE_SECTORS, tsec);
    write_register(REG_TABLE_COPIES, copies);
    write_register(REG_ROOT_ENTRIES, entries);
    write_register(REG_SECTOR_BYTES, sbytes);
    write_register(REG_CLUSTER_SECTORS, csec);
    cfg_we <= 1'b0;
  endtask

  // mix of table writes and lookups, any unwritten byte of a lookup written first
  task automatic run_random(int unsigned count);
    bit          burst;
    int unsigned done;
    int unsigned addr;
    stim_row_t   row;
    stim_row_t   fill;
    logic [11:0] cl;
    burst = ($urandom_range(0, 3) == 0);
    done = 0;
    while (done < count) begin
      row.has_exp = 1'b0;
      row.exp = '0;
      row.word.byte_offset = ADDR_BITS'($urandom);
      row.word.byte_value = 8'($urandom);
      row.word.cluster = CLUSTER_BITS'($urandom);
      if ($urandom_range(0, 9) < 4) begin
        row.word.func = FUNC_WRITE;
      end else begin
        row.word.func = FUNC_LOOKUP;
        case ($urandom_range(0, 9))
          0, 1, 2: cl = chain_next;
          3: begin
            case ($urandom_range(0, 5))
              0: cl = '0;
              1: cl = FIRST_DATA_CLUSTER - 12'd1;
              2: cl = FIRST_DATA_CLUSTER;
              3: cl = CHAIN_END_MIN - 12'd1;
              4: cl = CHAIN_END_MIN;
              default: cl = '1;
            endcase
          end
          default: cl = CLUSTER_BITS'($urandom);
        endcase
        row.word.cluster = cl;
        addr = 32'(cl);
        addr = addr + (addr >> 1);
        for (int k = 0; k < 2; k++) begin
          if (!fat_written[addr + k]) begin
            fill = write_row(addr + k, $urandom_range(0, 255));
            fill.word.cluster = CLUSTER_BITS'($urandom);
            send_item(fill, next_gap(burst));
            done++;
          end
        end
      end
      send_item(row, next_gap(burst));
      done++;
      if ($urandom_range(0, 199) == 0) drain();
    end
  endtask

  // result checker, the block cannot be held off
  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected word, next_cluster", 32'(out_word.next_cluster), '0);
      end else begin
        want = expected_words.pop_front();
        if (out_word.next_cluster !== want.next_cluster)
          report_mismatch("next_cluster", 32'(out_word.next_cluster), 32'(want.next_cluster));
        if (out_word.data_lba !== want.data_lba)
          report_mismatch("data_lba", out_word.data_lba, want.data_lba);
        if (out_word.root_start_lba !== want.root_start_lba)
          report_mismatch("root_start_lba", 32'(out_word.root_start_lba),
                          32'(want.root_start_lba));
        if (out_word.root_sector_count !== want.root_sector_count)
          report_mismatch("root_sector_count", 32'(out_word.root_sector_count),
                          32'(want.root_sector_count));
        if (out_word.chain_end !== want.chain_end)
          report_mismatch("chain_end", 32'(out_word.chain_end), 32'(want.chain_end));
        if (out_word.reserved_cluster !== want.reserved_cluster)
          report_mismatch("reserved_cluster", 32'(out_word.reserved_cluster),
                          32'(want.reserved_cluster));
      end
    end
  end

  // watchdog on cycles with no word moving in either direction
  always @(posedge clk) begin
    if (!rst_n || (start && busy === 1'b0) || out_valid === 1'b1 || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("fat12_cluster_chain_lookup regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    stim_row_t directed_rows[$];
    geo_reserved = RST_RESERVED_COUNT;
    geo_tsec = RST_TABLE_SECTORS;
    geo_copies = RST_TABLE_COPIES;
    geo_entries = RST_ROOT_ENTRIES;
    geo_sbytes = RST_SECTOR_BYTES;
    geo_csec = RST_CLUSTER_SECTORS;
    foreach (fat_image[i]) begin
      fat_image[i] = '0;
      fat_written[i] = 1'b0;
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // table bytes behind the corner clusters, media byte pattern first
    directed_rows.push_back(write_row(0, 'hF0));
    directed_rows.push_back(write_row(1, 'hFF));
    directed_rows.push_back(write_row(2, 'hFF));
    directed_rows.push_back(write_row(3, 'h03));
    directed_rows.push_back(write_row(4, 'h40));
    directed_rows.push_back(write_row(5, 'h00));
    directed_rows.push_back(write_row(6130, 'hAB));
    directed_rows.push_back(write_row(6131, 'hCD));
    directed_rows.push_back(write_row(6132, 'h12));
    directed_rows.push_back(write_row(6133, 'h34));
    directed_rows.push_back(write_row(6142, 'h5F));
    directed_rows.push_back(write_row(6143, 'hA0));
    directed_rows.push_back(write_row(DEPTH - 1, 'hFF));
    // reserved, first data, last data and end of chain clusters
    directed_rows.push_back(known_row(0, 'hFF0, 0, 1'b0, 1'b1));
    directed_rows.push_back(known_row(1, 'hFFF, 0, 1'b0, 1'b1));
    directed_rows.push_back(known_row(2, 'h003, 33, 1'b0, 1'b0));
    directed_rows.push_back(known_row(3, 'h004, 34, 1'b0, 1'b0));
    directed_rows.push_back(lookup_row('hFF7));
    directed_rows.push_back(known_row('hFF8, 'h412, 0, 1'b1, 1'b0));
    directed_rows.push_back(known_row('hFFF, 'hA05, 0, 1'b1, 1'b0));
    // lookup after a rewrite of its byte
    directed_rows.push_back(write_row(0, 'h00));
    directed_rows.push_back(known_row(0, 'hF00, 0, 1'b0, 1'b1));
    foreach (directed_rows[i]) send_item(directed_rows[i], next_gap(1'($urandom_range(0, 1))));

    run_random(RANDOM_PER_PHASE);
    for (int p = 1; p < PHASES; p++) begin
      case (p)
        1: program_geometry(16'hFFFF, 16'hFFFF, 16'h00FF, 16'hFFFF, 16'd1, 16'd128);
        2: program_geometry('0, '0, '0, '0, '0, '0);
        3: program_geometry(16'd32, 16'd9, 16'd1, 16'd512, 16'd4096, 16'd64);
        4: program_geometry('0, 16'd1, 16'd255, 16'd1, 16'h1FFF, 16'd255);
        default: program_geometry(16'($urandom), 16'($urandom), 16'($urandom),
                                  16'($urandom), 16'($urandom), 16'($urandom));
      endcase
      run_random(RANDOM_PER_PHASE);
    end

    drain();
    repeat (LATENCY_GUARD) @(posedge clk);
    if (mismatches == 0) begin
      $display("fat12_cluster_chain_lookup regression: pass");
    end else begin
      $display("fat12_cluster_chain_lookup regression: fail");
    end
    $finish;
  end

endmodule
